### src/tkpq_pkg.sv
package tkpq_pkg;

  // item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // largest execution time, 5.0 in 8 fraction bits
  localparam logic [10:0] TIME_MAX = 11'd1280;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIX,
    ST_INS,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] job_name;
    logic [2:0]  job_priority;
    logic [10:0] job_time;
  } tkpq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_name;
    logic [2:0]  out_priority;
    logic [10:0] out_time;
    logic [4:0]  occupancy;
  } tkpq_out_t;

endpackage

### src/two_key_priority_queue.sv
// Two-key priority queue for a job scheduler.
// Input channel (in_valid_i / in_stall_o, payload in_data_i): an insert stores
// a job in the lowest free slot, a pop removes the job with the smallest
// priority, then the smallest execution time, then the most recent insert.
// Output channel (out_valid_o / out_stall_i, payload out_data_o): exactly one
// result per input transfer, carrying status, the popped job and occupancy.
// One item is worked on at a time; in_stall_o is high while it is in flight.
// The job store is a single-port-read memory walked one slot per cycle.
// A pop from an empty store or an insert into a full store goes straight to
// the result with no walk of the store.
// A pop makes two walks (find the best job, then close the gap in recency
// ranks); an insert makes one walk (age held jobs, find a free slot).
// The result sits in an output register, so the next item is taken while a
// result waits; a finished item waits in its last state while a held result
// is stalled. Reset empties the queue at once; no clearing pass is needed.
module two_key_priority_queue
  import tkpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tkpq_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tkpq_out_t out_data_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  typedef struct packed {
    logic [31:0]   job_name;
    logic [2:0]    job_priority;
    logic [10:0]   job_time;
    logic [AW-1:0] age;
  } rec_t;

  // job store, recency rank kept with each job
  rec_t mem [QUEUE_DEPTH];

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        count_q, count_d;
  logic [QUEUE_DEPTH-1:0] valid_q, valid_d;
  logic                 p_q, p_d;
  logic [AW-1:0]        p_idx_q, p_idx_d;
  rec_t                 rd_q;
  tkpq_in_t             cmd_q, cmd_d;
  logic                 best_found_q, best_found_d;
  logic [AW-1:0]        best_idx_q, best_idx_d;
  rec_t                 best_rec_q, best_rec_d;
  logic                 free_found_q, free_found_d;
  logic [AW-1:0]        free_idx_q, free_idx_d;
  status_e              res_status_q, res_status_d;
  logic                 out_valid_q, out_valid_d;
  tkpq_out_t            out_q, out_d;

  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  rec_t                 mem_wd;
  logic                 mem_re;
  logic [AW-1:0]        rd_addr;
  logic [10:0]          sat_time;

  assign sat_time = (in_data_i.job_time > TIME_MAX) ? TIME_MAX : in_data_i.job_time;

  // store access, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      count_q      <= '0;
      valid_q      <= '0;
      p_q          <= 1'b0;
      best_found_q <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      count_q      <= count_d;
      valid_q      <= valid_d;
      p_q          <= p_d;
      best_found_q <= best_found_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p_idx_q      <= p_idx_d;
    cmd_q        <= cmd_d;
    best_idx_q   <= best_idx_d;
    best_rec_q   <= best_rec_d;
    free_idx_q   <= free_idx_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    count_d      = count_q;
    valid_d      = valid_q;
    p_d          = 1'b0;
    p_idx_d      = cnt_q[AW-1:0];
    cmd_d        = cmd_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_rec_d   = best_rec_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    res_status_d = res_status_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mem_we       = 1'b0;
    mem_wa       = p_idx_q;
    mem_wd       = rd_q;
    mem_re       = 1'b0;
    rd_addr      = cnt_q[AW-1:0];
    in_stall_o   = 1'b1;

    // walk issue: one store read per cycle
    if ((state_q == ST_SCAN || state_q == ST_FIX) && cnt_q != DEPTH_C) begin
      mem_re = 1'b1;
      p_d    = 1'b1;
      cnt_d  = cnt_q + 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_d          = in_data_i;
          cmd_d.job_time = sat_time;
          cnt_d          = '0;
          best_found_d   = 1'b0;
          free_found_d   = 1'b0;
          res_status_d   = STATUS_OK;
          if (in_data_i.kind == KIND_POP) begin
            if (count_q == '0) begin
              res_status_d = STATUS_EMPTY;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end else begin
            if (count_q == DEPTH_C) begin
              res_status_d = STATUS_FULL;
              state_d      = ST_DONE;
            end else begin
              state_d = ST_FIX;
            end
          end
        end
      end

      // find the best held job
      ST_SCAN: begin
        if (p_q && valid_q[p_idx_q] &&
            (!best_found_q ||
             {rd_q.job_priority, rd_q.job_time, rd_q.age} <
             {best_rec_q.job_priority, best_rec_q.job_time, best_rec_q.age})) begin
          best_found_d = 1'b1;
          best_idx_d   = p_idx_q;
          best_rec_d   = rd_q;
        end
        if (cnt_q == DEPTH_C) begin
          cnt_d   = '0;
          state_d = ST_FIX;
        end
      end

      // rewrite recency ranks, look for a free slot on insert
      ST_FIX: begin
        if (p_q) begin
          if (valid_q[p_idx_q]) begin
            if (cmd_q.kind == KIND_POP) begin
              if (rd_q.age > best_rec_q.age) begin
                mem_we     = 1'b1;
                mem_wd.age = rd_q.age - 1'b1;
              end
            end else begin
              mem_we     = 1'b1;
              mem_wd.age = rd_q.age + 1'b1;
            end
          end else if (!free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = p_idx_q;
          end
        end
        if (cnt_q == DEPTH_C) begin
          if (cmd_q.kind == KIND_POP) begin
            valid_d[best_idx_q] = 1'b0;
            count_d             = count_q - 1'b1;
            state_d             = ST_DONE;
          end else begin
            state_d = ST_INS;
          end
        end
      end

      // store the new job as the newest
      ST_INS: begin
        mem_we              = 1'b1;
        mem_wa              = free_idx_q;
        mem_wd.job_name     = cmd_q.job_name;
        mem_wd.job_priority = cmd_q.job_priority;
        mem_wd.job_time     = cmd_q.job_time;
        mem_wd.age          = '0;
        valid_d[free_idx_q] = 1'b1;
        count_d             = count_q + 1'b1;
        state_d             = ST_DONE;
      end

      // hand the result to the output register
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.status     = res_status_q;
          out_d.occupancy  = 5'(count_q);
          out_d.out_name   = '0;
          out_d.out_priority = '0;
          out_d.out_time   = '0;
          if (cmd_q.kind == KIND_POP && res_status_q == STATUS_OK) begin
            out_d.out_name     = best_rec_q.job_name;
            out_d.out_priority = best_rec_q.job_priority;
            out_d.out_time     = best_rec_q.job_time;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
